### rtl/mse_pkg.sv
// Package for the merge sort engine: data width, sequencer states and the
// control bundle of the buffer memories. No dependencies.

package mse_pkg;

	localparam int DATA_W = 32;

	typedef enum logic [1:0] {
		ST_LOAD,
		ST_PAIR,
		ST_MERGE,
		ST_EMIT
	} mse_state_t;

	typedef struct packed {
		logic wr_en;
		logic rd_a_en;
		logic rd_b_en;
	} mse_ram_ctl_t;

endpackage

### rtl/mse_if.sv
// Stream interfaces of the merge sort engine: input items and sorted results.
// Depends on mse_pkg for the data width.

interface mse_item_if import mse_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic signed [DATA_W-1:0] item_value;
	logic                     item_last;

	modport source(output valid, output item_value, output item_last, input ready);
	modport sink(input valid, input item_value, input item_last, output ready);
endinterface

interface mse_result_if import mse_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic signed [DATA_W-1:0] sorted_value;
	logic                     sorted_last;
	logic                     overflowed;

	modport source(output valid, output sorted_value, output sorted_last, output overflowed,
		input ready);
	modport sink(input valid, input sorted_value, input sorted_last, input overflowed,
		output ready);
endinterface

### rtl/mse_ram.sv
// Buffer memory of the merge sort engine: one write port, two read ports,
// read data registered and held until the next read. Depends on mse_pkg.

module mse_ram import mse_pkg::*; #(
	parameter int DEPTH = 64,
	parameter int AW    = 6
) (
	input  logic                     clk,
	input  mse_ram_ctl_t             ctl,
	input  logic [AW-1:0]            waddr,
	input  logic signed [DATA_W-1:0] wdata,
	input  logic [AW-1:0]            addr_a,
	input  logic [AW-1:0]            addr_b,
	output logic signed [DATA_W-1:0] rdata_a,
	output logic signed [DATA_W-1:0] rdata_b
);

	logic signed [DATA_W-1:0] mem [DEPTH];
	logic signed [DATA_W-1:0] rdata_a_q;
	logic signed [DATA_W-1:0] rdata_b_q;

	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem[waddr] <= wdata;
		end
		if (ctl.rd_a_en) begin
			rdata_a_q <= mem[addr_a];
		end
		if (ctl.rd_b_en) begin
			rdata_b_q <= mem[addr_b];
		end
	end

	assign rdata_a = rdata_a_q;
	assign rdata_b = rdata_b_q;

endmodule

### rtl/merge_sort_engine.sv
// Merge sort engine top level: batch load, bottom-up stable merge sort
// between two ping-pong buffers, and sorted emission.
// Depends on mse_pkg, mse_item_if, mse_result_if and mse_ram.
//
//   channel   dir   payload                                  accepted when
//   items     in    item_value, item_last                    valid && ready
//   results   out   sorted_value, sorted_last, overflowed    valid && ready
//
// In the load phase the input is always ready. The sort then runs
// ceil(log2 N) passes; each pass merges pairs of runs, each pair after a
// setup step, and writes one merged element at a time through the single
// write port of the destination buffer. Emission then delivers one item per
// cycle while the result output is not stalled; each result passes through
// the registered memory read and then the output register.
// arst_n clears the sequencer, counters and flags; buffer contents are not
// cleared. Input is stalled outside the load phase; a stalled result output
// holds the emission without losing data.

module merge_sort_engine import mse_pkg::*; #(
	parameter int MAX_ITEMS = 64
) (
	input  logic          clk,
	input  logic          arst_n,
	mse_item_if.sink      items,
	mse_result_if.source  results
);

	localparam int AW = $clog2(MAX_ITEMS);
	localparam int CW = $clog2(MAX_ITEMS + 1);
	localparam int XW = CW + 2;

	mse_state_t state_q, state_d;

	logic [CW-1:0] cnt_q, n_q, e_q, mv_q;
	logic          ovf_q, sel_q, pend_q;
	logic [XW-1:0] w_q, lo_q, mid_q, hi_q, i_q, j_q, k_q;

	logic                     out_val_q, out_last_q, out_ovf_q;
	logic signed [DATA_W-1:0] out_data_q;

	logic                     item_acc, store;
	logic [CW-1:0]            cnt_n;
	logic [XW-1:0]            n_x, w2, lo_w, lo_w2, mid_c, hi_c;
	logic signed [DATA_W-1:0] head_a, head_b, merged;
	logic                     a_ok, b_ok, take_a, pair_end, pass_end, sort_end;
	logic                     move, issue, last_move;

	mse_ram_ctl_t             ctl0, ctl1;
	logic [AW-1:0]            waddr, addr_a, addr_b;
	logic signed [DATA_W-1:0] wdata;
	logic signed [DATA_W-1:0] rd0_a, rd0_b, rd1_a, rd1_b;

	// sel_q picks the source buffer of the current pass: 0 reads buffer 0.
	mse_ram #(.DEPTH(MAX_ITEMS), .AW(AW)) u_buf0 (
		.clk(clk), .ctl(ctl0), .waddr(waddr), .wdata(wdata),
		.addr_a(addr_a), .addr_b(addr_b), .rdata_a(rd0_a), .rdata_b(rd0_b)
	);

	mse_ram #(.DEPTH(MAX_ITEMS), .AW(AW)) u_buf1 (
		.clk(clk), .ctl(ctl1), .waddr(waddr), .wdata(wdata),
		.addr_a(addr_a), .addr_b(addr_b), .rdata_a(rd1_a), .rdata_b(rd1_b)
	);

	always_comb begin
		item_acc = items.valid && items.ready;
		store    = cnt_q < CW'(MAX_ITEMS);
		cnt_n    = cnt_q + {{(CW-1){1'b0}}, store};

		n_x   = {2'b00, n_q};
		w2    = {w_q[XW-2:0], 1'b0};
		lo_w  = lo_q + w_q;
		lo_w2 = lo_q + w2;
		mid_c = (lo_w > n_x) ? n_x : lo_w;
		hi_c  = (lo_w2 > n_x) ? n_x : lo_w2;

		// The registered read data of each port is the head of its run.
		head_a = sel_q ? rd1_a : rd0_a;
		head_b = sel_q ? rd1_b : rd0_b;
		a_ok   = i_q < mid_q;
		b_ok   = j_q < hi_q;
		take_a = a_ok && (!b_ok || (head_a <= head_b));
		merged = take_a ? head_a : head_b;

		pair_end = (k_q + XW'(1)) == hi_q;
		pass_end = lo_w2 >= n_x;
		sort_end = w2 >= n_x;

		move      = pend_q && (!out_val_q || results.ready);
		issue     = (state_q == ST_EMIT) && (e_q < n_q) && (!pend_q || move);
		last_move = move && ((mv_q + CW'(1)) == n_q);
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_LOAD: begin
				if (item_acc && items.item_last) begin
					state_d = (cnt_n > CW'(1)) ? ST_PAIR : ST_EMIT;
				end
			end
			ST_PAIR: begin
				state_d = ST_MERGE;
			end
			ST_MERGE: begin
				if (pair_end) begin
					state_d = (!pass_end || !sort_end) ? ST_PAIR : ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (last_move) begin
					state_d = ST_LOAD;
				end
			end
			default: begin
				state_d = ST_LOAD;
			end
		endcase
	end

	always_comb begin
		logic          rd_a, rd_b;
		logic [XW-1:0] ra, rb;
		rd_a        = 1'b0;
		rd_b        = 1'b0;
		ra          = lo_q;
		rb          = mid_c;
		ctl0        = '0;
		ctl1        = '0;
		items.ready = 1'b0;
		waddr       = k_q[AW-1:0];
		wdata       = merged;
		case (state_q)
			ST_LOAD: begin
				items.ready = 1'b1;
				waddr       = cnt_q[AW-1:0];
				wdata       = items.item_value;
				ctl0.wr_en  = item_acc && store;
			end
			ST_PAIR: begin
				rd_a = 1'b1;
				rd_b = 1'b1;
			end
			ST_MERGE: begin
				rd_a       = take_a;
				rd_b       = !take_a;
				ra         = i_q + XW'(1);
				rb         = j_q + XW'(1);
				ctl0.wr_en = sel_q;
				ctl1.wr_en = !sel_q;
			end
			ST_EMIT: begin
				rd_a = issue;
				ra   = {2'b00, e_q};
			end
			default: begin
				rd_a = 1'b0;
			end
		endcase
		addr_a       = ra[AW-1:0];
		addr_b       = rb[AW-1:0];
		ctl0.rd_a_en = rd_a && !sel_q;
		ctl0.rd_b_en = rd_b && !sel_q;
		ctl1.rd_a_en = rd_a && sel_q;
		ctl1.rd_b_en = rd_b && sel_q;

		results.valid        = out_val_q;
		results.sorted_value = out_data_q;
		results.sorted_last  = out_last_q;
		results.overflowed   = out_ovf_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_LOAD;
			cnt_q     <= '0;
			ovf_q     <= 1'b0;
			n_q       <= '0;
			sel_q     <= 1'b0;
			w_q       <= '0;
			lo_q      <= '0;
			mid_q     <= '0;
			hi_q      <= '0;
			i_q       <= '0;
			j_q       <= '0;
			k_q       <= '0;
			e_q       <= '0;
			mv_q      <= '0;
			pend_q    <= 1'b0;
			out_val_q <= 1'b0;
		end else begin
			state_q <= state_d;
			case (state_q)
				ST_LOAD: begin
					if (item_acc) begin
						cnt_q <= cnt_n;
						ovf_q <= ovf_q | !store;
						if (items.item_last) begin
							n_q   <= cnt_n;
							sel_q <= 1'b0;
							w_q   <= XW'(1);
							lo_q  <= '0;
							e_q   <= '0;
							mv_q  <= '0;
						end
					end
				end
				ST_PAIR: begin
					mid_q <= mid_c;
					hi_q  <= hi_c;
					i_q   <= lo_q;
					j_q   <= mid_c;
					k_q   <= lo_q;
				end
				ST_MERGE: begin
					k_q <= k_q + XW'(1);
					if (take_a) begin
						i_q <= i_q + XW'(1);
					end else begin
						j_q <= j_q + XW'(1);
					end
					if (pair_end) begin
						if (!pass_end) begin
							lo_q <= lo_w2;
						end else begin
							// The destination becomes the source of the next pass.
							sel_q <= !sel_q;
							w_q   <= w2;
							lo_q  <= '0;
						end
					end
				end
				ST_EMIT: begin
					if (issue) begin
						e_q <= e_q + CW'(1);
					end
					if (move) begin
						mv_q <= mv_q + CW'(1);
					end
					pend_q <= issue || (pend_q && !move);
					if (last_move) begin
						cnt_q <= '0;
						ovf_q <= 1'b0;
					end
				end
				default: begin
					pend_q <= 1'b0;
				end
			endcase
			if (move) begin
				out_val_q <= 1'b1;
			end else if (results.ready) begin
				out_val_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (move) begin
			out_data_q <= head_a;
			out_last_q <= (mv_q + CW'(1)) == n_q;
			out_ovf_q  <= ovf_q;
		end
	end

endmodule

### verif/merge_sort_engine_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for merge_sort_engine: batches of signed items in, sorted items out.
// Depends on mse_pkg, mse_item_if, mse_result_if and the merge_sort_engine RTL.

module merge_sort_engine_test;
	import mse_pkg::*;

	localparam int CAPACITY    = 64;
	localparam int RANDOM_GOAL = 420;
	localparam int TAIL_CYCLES = 600;
	localparam int CYCLE_LIMIT = 300000;

	typedef struct packed {
		logic signed [DATA_W-1:0] value;
		logic                     last;
	} load_item_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] value;
		logic                     last;
		logic                     ovf;
	} sorted_item_t;

	typedef enum logic [1:0] {
		VAL_FULL,
		VAL_TIES,
		VAL_EXTREME
	} value_kind_t;

	typedef enum logic [1:0] {
		RX_FREE,
		RX_COIN,
		RX_PERIODIC
	} rx_mode_t;

	logic clk = 1'b0;
	logic arst_n;

	mse_item_if   items_ch();
	mse_result_if results_ch();

	merge_sort_engine #(
		.MAX_ITEMS(CAPACITY)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.items(items_ch),
		.results(results_ch)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	load_item_t   items_to_send[$];
	sorted_item_t sorted_due[$];

	// Shadow of the engine's batch buffer.
	logic signed [DATA_W-1:0] batch_buf [CAPACITY];
	int                       batch_count;
	logic                     batch_dropped;

	int errors;
	int batches_sorted;
	int overflow_batches;
	int results_checked;
	int items_loaded;
	int cycle_count;

	wire item_fire   = items_ch.valid && items_ch.ready;
	wire result_fire = results_ch.valid && results_ch.ready;

	// Stores or drops one accepted item; a last item sorts the batch and queues its output.
	task automatic load_and_sort(input load_item_t it);
		logic signed [DATA_W-1:0] run [CAPACITY];
		logic signed [DATA_W-1:0] key;
		sorted_item_t             res;
		int                       j;
		if (batch_count < CAPACITY) begin
			batch_buf[batch_count] = it.value;
			batch_count++;
		end else begin
			batch_dropped = 1'b1;
		end
		if (it.last) begin
			for (int i = 0; i < batch_count; i++)
				run[i] = batch_buf[i];
			// Insertion sort is stable, so equal keys keep their arrival order.
			for (int i = 1; i < batch_count; i++) begin
				key = run[i];
				j = i - 1;
				while (j >= 0 && run[j] > key) begin
					run[j + 1] = run[j];
					j--;
				end
				run[j + 1] = key;
			end
			for (int i = 0; i < batch_count; i++) begin
				res.value = run[i];
				res.last  = (i == batch_count - 1);
				res.ovf   = batch_dropped;
				sorted_due.push_back(res);
			end
			batches_sorted++;
			if (batch_dropped)
				overflow_batches++;
			batch_count   = 0;
			batch_dropped = 1'b0;
		end
	endtask

	function automatic logic signed [DATA_W-1:0] pick_value(input value_kind_t kind);
		logic signed [DATA_W-1:0] v;
		case (kind)
			VAL_TIES: v = $signed($urandom_range(0, 6)) - 3;
			VAL_EXTREME: begin
				case ($urandom_range(0, 4))
					0: v = 32'sh8000_0000;
					1: v = 32'sh7fff_ffff;
					2: v = '0;
					3: v = -1;
					default: v = $urandom;
				endcase
			end
			default: v = $urandom;
		endcase
		return v;
	endfunction

	task automatic add_item(input logic signed [DATA_W-1:0] v, input logic last);
		load_item_t it;
		it.value = v;
		it.last  = last;
		items_to_send.push_back(it);
	endtask

	task automatic add_batch(input int n, input value_kind_t kind);
		for (int i = 0; i < n; i++)
			add_item(pick_value(kind), i == n - 1);
	endtask

	// Sender: bursts of random length separated by random gaps; valid holds until accepted.
	int burst_left;
	int gap_left;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			items_ch.valid      <= 1'b0;
			items_ch.item_value <= '0;
			items_ch.item_last  <= 1'b0;
			burst_left = 0;
			gap_left   = 0;
		end else begin
			if (item_fire) begin
				load_and_sort(items_to_send[0]);
				items_to_send.pop_front();
				items_loaded++;
			end
			if (!items_ch.valid || item_fire) begin
				if (gap_left > 0) begin
					gap_left--;
					items_ch.valid <= 1'b0;
				end else if (items_to_send.size() > 0) begin
					items_ch.valid      <= 1'b1;
					items_ch.item_value <= items_to_send[0].value;
					items_ch.item_last  <= items_to_send[0].last;
					if (burst_left > 0) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(0, 12);
						gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
					end
				end else begin
					items_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Receiver: checks each accepted result and stalls in modes that change over time.
	rx_mode_t     rx_mode;
	int           rx_mode_left;
	int           rx_phase;
	sorted_item_t due;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			results_ch.ready <= 1'b0;
			rx_mode      = RX_FREE;
			rx_mode_left = 0;
			rx_phase     = 0;
		end else begin
			if (result_fire) begin
				results_checked++;
				if (sorted_due.size() == 0) begin
					$display("%0t: unexpected result value=%0d last=%0b overflowed=%0b", $time,
						results_ch.sorted_value, results_ch.sorted_last, results_ch.overflowed);
					errors++;
				end else begin
					due = sorted_due.pop_front();
					if (results_ch.sorted_value !== due.value) begin
						$display("%0t: sorted_value expected %0d actual %0d", $time, due.value,
							results_ch.sorted_value);
						errors++;
					end
					if (results_ch.sorted_last !== due.last) begin
						$display("%0t: sorted_last expected %0b actual %0b", $time, due.last,
							results_ch.sorted_last);
						errors++;
					end
					if (results_ch.overflowed !== due.ovf) begin
						$display("%0t: overflowed expected %0b actual %0b", $time, due.ovf,
							results_ch.overflowed);
						errors++;
					end
				end
			end
			if (rx_mode_left == 0) begin
				rx_mode      = rx_mode_t'($urandom_range(0, 2));
				rx_mode_left = $urandom_range(40, 200);
			end else begin
				rx_mode_left--;
			end
			rx_phase = (rx_phase + 1) % 9;
			case (rx_mode)
				RX_COIN:     results_ch.ready <= ($urandom_range(0, 3) != 0);
				RX_PERIODIC: results_ch.ready <= (rx_phase >= 5);
				default:     results_ch.ready <= 1'b1;
			endcase
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d items unsent and %0d results outstanding", $time,
				items_to_send.size(), sorted_due.size());
			$display("[merge_sort_engine] ERROR");
			$finish;
		end
	end

	initial begin
		int          random_items;
		int          batch_idx;
		int          n;
		int          pick;
		value_kind_t kind;

		arst_n              = 1'b0;
		items_ch.valid      = 1'b0;
		items_ch.item_value = '0;
		items_ch.item_last  = 1'b0;
		results_ch.ready    = 1'b0;
		batch_count         = 0;
		batch_dropped       = 1'b0;
		errors              = 0;
		batches_sorted      = 0;
		overflow_batches    = 0;
		results_checked     = 0;
		items_loaded        = 0;
		cycle_count         = 0;

		// A batch of one item.
		add_item(5, 1'b1);
		// Both ends of the signed range, with duplicates mixed in.
		add_item(32'sh7fff_ffff, 1'b0);
		add_item(32'sh8000_0000, 1'b0);
		add_item(0, 1'b0);
		add_item(-1, 1'b0);
		add_item(1, 1'b0);
		add_item(32'sh8000_0001, 1'b0);
		add_item(32'sh7fff_fffe, 1'b0);
		add_item(32'sh8000_0000, 1'b0);
		add_item(0, 1'b0);
		add_item(32'sh7fff_ffff, 1'b1);
		// Already ascending, then descending with equal keys.
		add_item(-2, 1'b0);
		add_item(-1, 1'b0);
		add_item(0, 1'b0);
		add_item(1, 1'b1);
		add_item(3, 1'b0);
		add_item(3, 1'b0);
		add_item(2, 1'b0);
		add_item(2, 1'b0);
		add_item(1, 1'b1);

		// Mostly small batches; a few fill the buffer exactly or run past it.
		random_items = 0;
		batch_idx    = 0;
		while (random_items < RANDOM_GOAL) begin
			pick = $urandom_range(0, 29);
			if (batch_idx == 2 || pick == 0)
				n = CAPACITY;
			else if (batch_idx == 5 || batch_idx == 11 || pick == 1)
				n = CAPACITY + $urandom_range(1, 4);
			else
				n = $urandom_range(1, 14);
			kind = value_kind_t'($urandom_range(0, 2));
			add_batch(n, kind);
			random_items += n;
			batch_idx++;
		end

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		while (items_to_send.size() > 0 || sorted_due.size() > 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Loaded %0d items in %0d batches (%0d overflowed); checked %0d sorted results.",
			items_loaded, batches_sorted, overflow_batches, results_checked);
		if (errors == 0)
			$display("[merge_sort_engine] OK");
		else
			$display("[merge_sort_engine] ERROR");
		$finish;
	end

endmodule

### files.f
rtl/mse_pkg.sv
rtl/mse_if.sv
rtl/mse_ram.sv
rtl/merge_sort_engine.sv
verif/merge_sort_engine_test.sv
